>>> rtl/core/bitplane_group_test_encoder_defines.svh
// Assertion macros, compiled out when NO_ASSERTIONS is set.
`ifndef BITPLANE_GROUP_TEST_ENCODER_DEFINES_SVH
`define BITPLANE_GROUP_TEST_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BGTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BGTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define BGTE_ASSERT(label, prop, msg)
`define BGTE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/bgte_pkg.sv
package bgte_pkg;

    localparam int CHUNK_W = 64;
    localparam int CNT_W   = 7;
    localparam int BUD_W   = 8;
    localparam int GRP_W   = 8;
    localparam int NGRP    = CHUNK_W / GRP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VERB,
        ST_TEST,
        ST_WAIT,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_VERB,
        OP_TEST,
        OP_SCAN,
        OP_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic hold;     // overflowing emit or flush blocked by a full, stalled output register
        logic test_go;  // budget left and coefficients left
        logic lb;       // group test bit
        logic hit;      // scan ran into the budget
        logic resume;   // continue an interrupted group scan
    } status_t;

endpackage

>>> rtl/core/bitplane_group_test_encoder.sv
// Channel   Handshake                  Payload
// config    cfg_wr_en                  cfg_wr_data (resume_inside_group)
// plane     plane_valid / plane_stall  plane_bits, budget, new_block, new_plane
// chunk     chunk_valid / chunk_stall  chunk_bits, chunk_count, last, plane_done,
//                                      significant_now
// Each plane beat is accepted, then runs a verbatim step, group tests and leading-one scans,
// and a flush; a resumed group scan adds a wait state for the registered trailing-zero unit
// and has no test of its own.
// Reset clears the coding state and sets resume_inside_group to 1.
// A pushed chunk that waits on chunk_stall holds the sequencer only when another chunk must be pushed; plane
// is taken again as soon as the final chunk sits in the output register.
`include "bitplane_group_test_encoder_defines.svh"

module bitplane_group_test_encoder
    import bgte_pkg::*;
#(
    parameter int COEFFS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               plane_valid,
    output logic               plane_stall,
    input  logic [CHUNK_W-1:0] plane_bits,
    input  logic [BUD_W-1:0]   budget,
    input  logic               new_block,
    input  logic               new_plane,
    output logic               chunk_valid,
    input  logic               chunk_stall,
    output logic [CHUNK_W-1:0] chunk_bits,
    output logic [CNT_W-1:0]   chunk_count,
    output logic               last,
    output logic               plane_done,
    output logic [CNT_W-1:0]   significant_now
);

    cmd_t    cmd;
    status_t status;

    bgte_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .plane_valid (plane_valid),
        .plane_stall (plane_stall),
        .status      (status),
        .cmd         (cmd)
    );

    bgte_dp #(
        .COEFFS (COEFFS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .plane_bits      (plane_bits),
        .budget          (budget),
        .new_block       (new_block),
        .new_plane       (new_plane),
        .cmd             (cmd),
        .status          (status),
        .chunk_valid     (chunk_valid),
        .chunk_stall     (chunk_stall),
        .chunk_bits      (chunk_bits),
        .chunk_count     (chunk_count),
        .last            (last),
        .plane_done      (plane_done),
        .significant_now (significant_now)
    );

    `BGTE_ASSERT(a_mid_chunk_full, chunk_valid && !last |-> chunk_count == 7'd64, "short chunk")
    `BGTE_ASSERT_NEXT(a_busy_after_beat, plane_valid && !plane_stall, plane_stall, "not busy")

endmodule

>>> rtl/core/bgte_tzc.sv
module bgte_tzc
    import bgte_pkg::*;
(
    input  logic               clk,
    input  logic [CHUNK_W-1:0] x,
    output logic [CNT_W-1:0]   tz
);

    logic [NGRP-1:0] nz_reg;
    logic [2:0]      gtz_reg [NGRP];

    function automatic logic [2:0] tz8(input logic [GRP_W-1:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (b[i])
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++) begin
            nz_reg[g]  <= |x[g*GRP_W +: GRP_W];
            gtz_reg[g] <= tz8(x[g*GRP_W +: GRP_W]);
        end
    end

    always_comb
    begin
        tz = 7'(CHUNK_W);
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (nz_reg[g])
            begin
                tz = {1'b0, 3'(g), gtz_reg[g]};
            end
        end
    end

endmodule

>>> rtl/core/bgte_ctrl.sv
module bgte_ctrl
    import bgte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    plane_valid,
    output logic    plane_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (plane_valid)
                begin
                    state_next = ST_VERB;
                end
            end
            ST_VERB:
            begin
                if (!status.hold)
                begin
                    state_next = status.resume ? ST_WAIT : ST_TEST;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_SCAN;
            end
            ST_TEST:
            begin
                if (!status.hold)
                begin
                    state_next = (status.test_go && status.lb) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (!status.hold)
                begin
                    state_next = status.hit ? ST_FIN : ST_TEST;
                end
            end
            ST_FIN:
            begin
                if (!status.hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op      = OP_NONE;
        plane_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE: cmd.op = plane_valid ? OP_ACCEPT : OP_NONE;
            ST_VERB: cmd.op = OP_VERB;
            ST_WAIT: cmd.op = OP_NONE;
            ST_TEST: cmd.op = OP_TEST;
            ST_SCAN: cmd.op = OP_SCAN;
            ST_FIN:  cmd.op = OP_FIN;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/core/bgte_dp.sv
`include "bitplane_group_test_encoder_defines.svh"

module bgte_dp
    import bgte_pkg::*;
#(
    parameter int COEFFS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic [CHUNK_W-1:0] plane_bits,
    input  logic [BUD_W-1:0]   budget,
    input  logic               new_block,
    input  logic               new_plane,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               chunk_valid,
    input  logic               chunk_stall,
    output logic [CHUNK_W-1:0] chunk_bits,
    output logic [CNT_W-1:0]   chunk_count,
    output logic               last,
    output logic               plane_done,
    output logic [CNT_W-1:0]   significant_now
);

    localparam logic [CHUNK_W-1:0] COEF_MASK = (64'd1 << COEFFS) - 64'd1;
    localparam logic [CNT_W-1:0]   NCOEF     = CNT_W'(COEFFS);
    localparam logic [CNT_W-1:0]   LAST_IDX  = CNT_W'(COEFFS - 1);

    // coding state
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               in_group_reg, in_group_next;
    logic               rig_reg, rig_next;
    // per-call work registers
    logic [CHUNK_W-1:0] x_reg, x_next;
    logic [BUD_W-1:0]   lim_reg, lim_next;
    logic [BUD_W-1:0]   acc_reg, acc_next;
    logic               lb_zero_reg, lb_zero_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    // output register
    logic               ob_valid_reg, ob_valid_next;
    logic [CHUNK_W-1:0] ob_bits_reg, ob_bits_next;
    logic [CNT_W-1:0]   ob_count_reg, ob_count_next;
    logic               ob_last_reg, ob_last_next;
    logic               ob_done_reg, ob_done_next;
    logic [CNT_W-1:0]   ob_sig_reg, ob_sig_next;

    logic [CNT_W-1:0]     tz;
    logic                 out_free;
    logic                 emit_en;
    logic [CHUNK_W-1:0]   seg;
    logic [CNT_W-1:0]     seg_len;
    logic [BUD_W-1:0]     sum;
    logic                 over;
    logic [2*CHUNK_W-1:0] wide;
    logic [CNT_W-1:0]     verb, take, maxc, kz, adv;
    logic [BUD_W-1:0]     avail, acc_new;
    logic                 case1, hit, test_go, lb, resume, done, push;

    function automatic logic [CHUNK_W-1:0] lowmask(input logic [CNT_W-1:0] len);
        logic [CHUNK_W-1:0] m;
        m = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            m[i] = (CNT_W'(i) < len);
        end
        return m;
    endfunction

    bgte_tzc u_tzc (
        .clk (clk),
        .x   (x_reg),
        .tz  (tz)
    );

    assign out_free = !ob_valid_reg || !chunk_stall;

    // verbatim part
    assign verb = (n_reg > pos_reg) ? CNT_W'(n_reg - pos_reg) : '0;
    assign take = ({1'b0, verb} < lim_reg) ? verb : lim_reg[CNT_W-1:0];

    // group test
    assign test_go = (acc_reg < lim_reg) && (n_reg < NCOEF);
    assign lb      = |x_reg;
    assign resume  = rig_reg && in_group_reg && (n_reg < NCOEF);

    // leading-one scan
    assign avail   = lim_reg - acc_reg;
    assign maxc    = LAST_IDX - n_reg;
    assign case1   = (tz < maxc) && ({1'b0, tz} < avail);
    assign kz      = ({1'b0, maxc} < avail) ? maxc : avail[CNT_W-1:0];
    assign acc_new = acc_reg + {1'b0, seg_len};
    assign hit     = (acc_new >= lim_reg);
    assign adv     = case1 ? (hit ? tz : CNT_W'(tz + 7'd1))
                           : (hit ? kz : CNT_W'(kz + 7'd1));

    assign done = ((n_reg == NCOEF) && (pos_reg == n_reg)) || lb_zero_reg;

    always_comb
    begin
        emit_en = 1'b0;
        seg     = '0;
        seg_len = '0;
        unique case (cmd.op)
            OP_VERB:
            begin
                emit_en = 1'b1;
                seg     = x_reg & lowmask(take);
                seg_len = take;
            end
            OP_TEST:
            begin
                emit_en = test_go;
                seg     = {{(CHUNK_W-1){1'b0}}, lb};
                seg_len = test_go ? 7'd1 : 7'd0;
            end
            OP_SCAN:
            begin
                emit_en = 1'b1;
                seg     = case1 ? (64'd1 << tz) : '0;
                seg_len = case1 ? CNT_W'(tz + 7'd1) : kz;
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    assign sum  = {1'b0, fill_reg} + {1'b0, seg_len};
    assign over = emit_en && (sum > 8'd64);
    assign wide = {{CHUNK_W{1'b0}}, chunk_reg} | ({{CHUNK_W{1'b0}}, seg} << fill_reg);

    always_comb
    begin
        status.hold    = (over && !out_free) || ((cmd.op == OP_FIN) && !out_free);
        status.test_go = test_go;
        status.lb      = lb;
        status.hit     = hit;
        status.resume  = resume;
    end

    always_comb
    begin
        n_next        = n_reg;
        pos_next      = pos_reg;
        in_group_next = in_group_reg;
        rig_next      = cfg_wr_en ? cfg_wr_data : rig_reg;
        x_next        = x_reg;
        lim_next      = lim_reg;
        acc_next      = acc_reg;
        lb_zero_next  = lb_zero_reg;
        chunk_next    = chunk_reg;
        fill_next     = fill_reg;
        push          = 1'b0;
        ob_bits_next  = ob_bits_reg;
        ob_count_next = ob_count_reg;
        ob_last_next  = ob_last_reg;
        ob_done_next  = ob_done_reg;
        ob_sig_next   = ob_sig_reg;

        if (!status.hold)
        begin
            if (emit_en)
            begin
                acc_next = acc_new;
                if (over)
                begin
                    push          = 1'b1;
                    ob_bits_next  = wide[CHUNK_W-1:0];
                    ob_count_next = 7'd64;
                    ob_last_next  = 1'b0;
                    ob_done_next  = 1'b0;
                    ob_sig_next   = '0;
                    chunk_next    = wide[2*CHUNK_W-1:CHUNK_W];
                    fill_next     = CNT_W'(sum - 8'd64);
                end
                else
                begin
                    chunk_next = wide[CHUNK_W-1:0];
                    fill_next  = sum[CNT_W-1:0];
                end
            end

            unique case (cmd.op)
                OP_ACCEPT:
                begin
                    n_next        = new_block ? '0 : n_reg;
                    pos_next      = (new_block || new_plane) ? '0 : pos_reg;
                    in_group_next = (new_block || new_plane) ? 1'b0 : in_group_reg;
                    x_next        = (plane_bits & COEF_MASK)
                                    >> ((new_block || new_plane) ? 7'd0 : pos_reg);
                    lim_next      = budget;
                    acc_next      = '0;
                    lb_zero_next  = 1'b0;
                end
                OP_VERB:
                begin
                    x_next        = x_reg >> take;
                    pos_next      = pos_reg + take;
                    in_group_next = 1'b0;
                end
                OP_TEST:
                begin
                    if (test_go && !lb)
                    begin
                        lb_zero_next = 1'b1;
                    end
                end
                OP_SCAN:
                begin
                    n_next        = n_reg + adv;
                    pos_next      = pos_reg + adv;
                    x_next        = x_reg >> adv;
                    in_group_next = hit && rig_reg;
                end
                OP_FIN:
                begin
                    push          = 1'b1;
                    ob_bits_next  = chunk_reg;
                    ob_count_next = fill_reg;
                    ob_last_next  = 1'b1;
                    ob_done_next  = done;
                    ob_sig_next   = n_reg;
                    chunk_next    = '0;
                    fill_next     = '0;
                end
                OP_NONE:
                begin
                    x_next = x_reg;
                end
                default:
                begin
                    x_next = x_reg;
                end
            endcase
        end

        if (push)
        begin
            ob_valid_next = 1'b1;
        end
        else if (!chunk_stall)
        begin
            ob_valid_next = 1'b0;
        end
        else
        begin
            ob_valid_next = ob_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= '0;
            pos_reg      <= '0;
            in_group_reg <= 1'b0;
            rig_reg      <= 1'b1;
            acc_reg      <= '0;
            lb_zero_reg  <= 1'b0;
            chunk_reg    <= '0;
            fill_reg     <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg        <= n_next;
            pos_reg      <= pos_next;
            in_group_reg <= in_group_next;
            rig_reg      <= rig_next;
            acc_reg      <= acc_next;
            lb_zero_reg  <= lb_zero_next;
            chunk_reg    <= chunk_next;
            fill_reg     <= fill_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        lim_reg      <= lim_next;
        ob_bits_reg  <= ob_bits_next;
        ob_count_reg <= ob_count_next;
        ob_last_reg  <= ob_last_next;
        ob_done_reg  <= ob_done_next;
        ob_sig_reg   <= ob_sig_next;
    end

    assign chunk_valid     = ob_valid_reg;
    assign chunk_bits      = ob_bits_reg;
    assign chunk_count     = ob_count_reg;
    assign last            = ob_last_reg;
    assign plane_done      = ob_done_reg;
    assign significant_now = ob_sig_reg;

    `BGTE_ASSERT(a_pos_within_count, pos_reg <= n_reg, "position past count")
    `BGTE_ASSERT(a_fill_range, fill_reg <= 7'd64, "chunk fill above 64")
    `BGTE_ASSERT_NEXT(a_fin_clears, cmd.op == OP_FIN && !status.hold, fill_reg == '0, "no flush")

endmodule

>>> sim/bgte_tb_pkg.sv
package bgte_tb_pkg;

    import bgte_pkg::*;

    typedef struct packed {
        logic [CHUNK_W-1:0] bits;
        logic [CNT_W-1:0]   count;
        logic               last;
        logic               done;
        logic [CNT_W-1:0]   sig;
    } chunk_t;

    class group_test_scoreboard;

        localparam int NCOEF = 64;

        chunk_t               chunks_due[$];
        bit                   resume_en = 1'b1;
        int                   sig_count = 0;
        int                   plane_pos = 0;
        bit                   in_group = 1'b0;
        bit                   plane_finished = 1'b0;
        int                   fails = 0;
        int                   seen = 0;
        logic [3*CHUNK_W-1:0] acc;
        int                   acc_n;

        task report(string msg);
            $display("ERROR chunk %0d: %0s", seen, msg);
            fails++;
        endtask

        function void put_bit(logic b);
            if (acc_n < 3 * CHUNK_W)
                acc[acc_n] = b;
            acc_n++;
        endfunction

        // Codes one plane beat and queues the chunks it must produce.
        function void note_plane(logic [CHUNK_W-1:0] bits, logic [BUD_W-1:0] bud,
                                 logic nb, logic np);
            logic [CHUNK_W-1:0] x;
            int                 n;
            int                 m;
            int                 p;
            int                 lim;
            int                 take;
            int                 nres;
            int                 rem;
            bit                 resume;
            bit                 lb;
            bit                 b;
            chunk_t             c;

            if (nb)
            begin
                sig_count = 0;
                plane_pos = 0;
                in_group = 1'b0;
            end
            if (np)
            begin
                plane_pos = 0;
                in_group = 1'b0;
            end
            acc = '0;
            acc_n = 0;
            lim = int'(bud);
            n = sig_count;
            m = plane_pos;
            x = (m >= NCOEF) ? '0 : (bits >> m);

            // significant coefficients go out verbatim
            take = (n > m) ? n - m : 0;
            if (take > lim)
                take = lim;
            for (int i = 0; i < take; i++)
            begin
                put_bit(x[0]);
                x = x >> 1;
            end
            p = take;

            resume = resume_en && in_group && (n < NCOEF);
            in_group = 1'b0;
            lb = 1'b1;
            forever
            begin
                if (!resume)
                begin
                    if (!(acc_n < lim && n < NCOEF))
                        break;
                    lb = (x != '0);
                    put_bit(lb);
                    if (!lb)
                        break;
                end
                resume = 1'b0;
                while (acc_n < lim && n < NCOEF - 1)
                begin
                    b = x[0];
                    put_bit(b);
                    if (b)
                        break;
                    x = x >> 1;
                    n++;
                    p++;
                end
                if (acc_n >= lim)
                begin
                    if (resume_en)
                        in_group = 1'b1;
                    break;
                end
                x = x >> 1;
                n++;
                p++;
            end

            m += p;
            plane_finished = (n == NCOEF && m == n) || !lb;
            sig_count = n & 'h7F;
            plane_pos = m & 'h7F;

            nres = (acc_n == 0) ? 1 : (acc_n + 63) / 64;
            if (nres > 3)
                nres = 3;
            for (int k = 0; k < nres; k++)
            begin
                rem = (acc_n > 64 * k) ? acc_n - 64 * k : 0;
                c.bits = acc[64*k +: 64];
                c.count = CNT_W'((rem > 64) ? 64 : rem);
                c.last = (k == nres - 1);
                c.done = c.last && plane_finished;
                c.sig = c.last ? CNT_W'(sig_count) : '0;
                chunks_due.push_back(c);
            end
        endfunction

        task check_chunk(chunk_t got);
            chunk_t want;

            seen++;
            if (chunks_due.size() == 0)
            begin
                report($sformatf("unexpected beat bits=%h count=%0d", got.bits, got.count));
                return;
            end
            want = chunks_due.pop_front();
            if (got.bits !== want.bits)
                report($sformatf("chunk_bits %h, want %h", got.bits, want.bits));
            if (got.count !== want.count)
                report($sformatf("chunk_count %0d, want %0d", got.count, want.count));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
            if (got.done !== want.done)
                report($sformatf("plane_done %b, want %b", got.done, want.done));
            if (got.sig !== want.sig)
                report($sformatf("significant_now %0d, want %0d", got.sig, want.sig));
        endtask

    endclass

endpackage

>>> sim/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bgte_pkg::*;
    import bgte_tb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 150;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               plane_valid = 1'b0;
    logic               plane_stall;
    logic [CHUNK_W-1:0] plane_bits = '0;
    logic [BUD_W-1:0]   budget = '0;
    logic               new_block = 1'b0;
    logic               new_plane = 1'b0;
    logic               chunk_valid;
    logic               chunk_stall = 1'b0;
    logic [CHUNK_W-1:0] chunk_bits;
    logic [CNT_W-1:0]   chunk_count;
    logic               last;
    logic               plane_done;
    logic [CNT_W-1:0]   significant_now;

    group_test_scoreboard sb;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          quiet_tail = 1'b0;
    bit          long_hold_req = 1'b0;
    int          rx_gap_left = 0;
    int          rx_hold_left = 0;
    int unsigned cycle_count = 0;

    bitplane_group_test_encoder #(
        .COEFFS(64)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .plane_valid(plane_valid),
        .plane_stall(plane_stall),
        .plane_bits(plane_bits),
        .budget(budget),
        .new_block(new_block),
        .new_plane(new_plane),
        .chunk_valid(chunk_valid),
        .chunk_stall(chunk_stall),
        .chunk_bits(chunk_bits),
        .chunk_count(chunk_count),
        .last(last),
        .plane_done(plane_done),
        .significant_now(significant_now)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // chunk side: check accepted beats, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chunk_valid && !chunk_stall)
                sb.check_chunk(chunk_t'({chunk_bits, chunk_count, last, plane_done,
                                         significant_now}));
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                chunk_stall <= 1'b1;
            end
            else if (rx_gap_left > 0)
            begin
                rx_gap_left--;
                chunk_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                rx_gap_left = $urandom_range(1, 3) - 1;
                chunk_stall <= 1'b1;
            end
            else
                chunk_stall <= 1'b0;
        end
    end

    task automatic send_plane(logic [CHUNK_W-1:0] bits, logic [BUD_W-1:0] bud,
                              logic nb, logic np);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            plane_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        plane_valid <= 1'b1;
        plane_bits <= bits;
        budget <= bud;
        new_block <= nb;
        new_plane <= np;
        do
            @(posedge clk);
        while (plane_stall);
        sb.note_plane(bits, bud, nb, np);
    endtask

    task automatic write_resume(logic v);
        plane_valid <= 1'b0;
        while (sb.chunks_due.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.resume_en = v;
    endtask

    function automatic logic [CHUNK_W-1:0] rand_plane();
        logic [CHUNK_W-1:0] v;

        case ($urandom_range(0, 5))
            0:
            begin
                v = '0;
                repeat ($urandom_range(1, 4)) v[$urandom_range(0, 63)] = 1'b1;
            end
            1: v = {$urandom, $urandom} & {$urandom, $urandom};
            2: v = {$urandom, $urandom};
            3: v = {$urandom, $urandom} | {$urandom, $urandom};
            4: v = {$urandom, $urandom} << $urandom_range(0, 63);
            default: v = ($urandom_range(0, 1) != 0) ? '0 : '1;
        endcase
        return v;
    endfunction

    function automatic logic [BUD_W-1:0] rand_budget();
        int r;

        r = $urandom_range(0, 9);
        if (r < 6)
            return BUD_W'($urandom_range(0, 24));
        else if (r < 8)
            return BUD_W'($urandom_range(25, 128));
        else
            return BUD_W'($urandom_range(129, 255));
    endfunction

    task automatic run_directed();
        send_plane('0, 8'd255, 1'b1, 1'b1);
        send_plane('1, 8'd255, 1'b1, 1'b1);
        send_plane('1, 8'd255, 1'b0, 1'b1);
        send_plane({$urandom, $urandom}, 8'd129, 1'b0, 1'b0);
        send_plane(64'h8000_0000_0000_0000, 8'd128, 1'b1, 1'b0);
        send_plane(64'h5, 8'd0, 1'b1, 1'b1);
        send_plane(64'hF, 8'd255, 1'b1, 1'b1);
        send_plane(64'hA5A5_5A5A_F00F_0FF0, 8'd2, 1'b0, 1'b1);
        send_plane(64'hA5A5_5A5A_F00F_0FF0, 8'd2, 1'b0, 1'b0);
        send_plane(64'hA5A5_5A5A_F00F_0FF0, 8'd255, 1'b0, 1'b0);
        // budget runs out inside a group, then right on the found one
        for (int r = 0; r < 2; r++)
        begin
            if (r == 1)
                write_resume(1'b0);
            send_plane(64'h20, 8'd6, 1'b1, 1'b1);
            send_plane(64'h20, 8'd1, 1'b0, 1'b0);
            send_plane(64'h20, 8'd255, 1'b0, 1'b0);
            send_plane(64'hFFFF_0000_0000_0001, 8'd1, 1'b1, 1'b1);
            send_plane(64'hFFFF_0000_0000_0001, 8'd255, 1'b0, 1'b0);
        end
    endtask

    // Mostly whole blocks: planes coded over budget-limited calls until done, at most 12 calls each.
    task automatic run_blocks(int items);
        int                 sent;
        int                 planes;
        int                 calls;
        logic [CHUNK_W-1:0] bits;
        logic               nb;
        logic               np;

        sent = 0;
        while (sent < items)
        begin
            if (!quiet_tail)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_plane({$urandom, $urandom}, BUD_W'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                planes = $urandom_range(1, 6);
                for (int pl = 0; pl < planes && sent < items; pl++)
                begin
                    bits = rand_plane();
                    calls = 0;
                    do
                    begin
                        nb = (pl == 0 && calls == 0);
                        np = (calls == 0) && (pl != 0 || $urandom_range(0, 1) != 0);
                        if (calls > 0 && $urandom_range(0, 19) == 0)
                            bits = rand_plane();
                        send_plane(bits, rand_budget(), nb, np);
                        calls++;
                        sent++;
                    end
                    while (!sb.plane_finished && calls < 12 && sent < items);
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        write_resume(1'b1);
        long_hold_req = 1'b1;
        run_blocks(105);

        write_resume(1'b0);
        run_blocks(100);

        write_resume(1'b1);
        run_blocks(100);

        quiet_tail = 1'b1;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_resume(1'b0);
        run_blocks(100);

        plane_valid <= 1'b0;
        while (sb.chunks_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
